### design/bpgs_pkg.sv
// shared constants, request codes and types of the bit-parallel gate simulator
package bpgs_pkg;

    localparam int NODES     = 1024;
    localparam int NODE_W    = $clog2(NODES);
    localparam int LANES     = 64;
    localparam int WORD_W    = 64;
    localparam int MAX_FANIN = 4;
    localparam int FAN_W     = $clog2(MAX_FANIN);
    localparam int CNT_W     = $clog2(MAX_FANIN + 1);
    localparam int DEPTH     = 2 * NODES;
    localparam int ADDR_W    = NODE_W + 1;

    localparam logic [WORD_W-1:0] LANE_MASK = {WORD_W{1'b1}} >> (WORD_W - LANES);

    localparam logic [2:0] REQ_INPUT = 3'd0;
    localparam logic [2:0] REQ_GATE  = 3'd1;
    localparam logic [2:0] REQ_COPY  = 3'd2;
    localparam logic [2:0] REQ_XFER  = 3'd3;
    localparam logic [2:0] REQ_CHECK = 3'd4;

    localparam logic [3:0] GK_C0   = 4'd0;
    localparam logic [3:0] GK_C1   = 4'd1;
    localparam logic [3:0] GK_BUF  = 4'd2;
    localparam logic [3:0] GK_NOT  = 4'd3;
    localparam logic [3:0] GK_AND  = 4'd4;
    localparam logic [3:0] GK_NAND = 4'd5;
    localparam logic [3:0] GK_OR   = 4'd6;
    localparam logic [3:0] GK_NOR  = 4'd7;
    localparam logic [3:0] GK_XOR  = 4'd8;
    localparam logic [3:0] GK_XNOR = 4'd9;

    localparam logic [1:0] PV_ZERO = 2'd0;
    localparam logic [1:0] PV_ONE  = 2'd1;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_check;
        logic [WORD_W-1:0] mask;
        logic              wr_en;
    } eval_res_t;

endpackage

### design/bpgs_ram.sv
// generic single-write, single-read ram with registered read data
module bpgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/bpgs_eval.sv
// result word, check mask update and write decision for one record
module bpgs_eval (
    input  logic [2:0]                 req,
    input  logic [3:0]                 kind,
    input  logic [1:0]                 pv,
    input  logic                       last,
    input  logic [bpgs_pkg::WORD_W-1:0] rand_word,
    input  logic [bpgs_pkg::WORD_W-1:0] w0,
    input  logic [bpgs_pkg::WORD_W-1:0] acc_and,
    input  logic [bpgs_pkg::WORD_W-1:0] acc_or,
    input  logic [bpgs_pkg::WORD_W-1:0] acc_xor,
    input  logic [bpgs_pkg::WORD_W-1:0] mask,
    output bpgs_pkg::eval_res_t        res
);
    import bpgs_pkg::*;

    logic [WORD_W-1:0] gate_word;
    logic [WORD_W-1:0] term_mask;

    always_comb begin
        case (kind)
            GK_C0:   gate_word = '0;
            GK_C1:   gate_word = '1;
            GK_BUF:  gate_word = w0;
            GK_NOT:  gate_word = ~w0;
            GK_AND:  gate_word = acc_and;
            GK_NAND: gate_word = ~acc_and;
            GK_OR:   gate_word = acc_or;
            GK_NOR:  gate_word = ~acc_or;
            GK_XOR:  gate_word = acc_xor;
            GK_XNOR: gate_word = ~acc_xor;
            default: gate_word = '0;
        endcase
    end

    always_comb begin
        term_mask = mask;
        if (pv == PV_ONE) begin
            term_mask = mask & w0;
        end else if (pv == PV_ZERO) begin
            term_mask = mask & ~w0;
        end
        term_mask = term_mask & LANE_MASK;
    end

    always_comb begin
        res.word     = '0;
        res.is_check = 1'b0;
        res.mask     = mask;
        res.wr_en    = 1'b0;
        case (req)
            REQ_INPUT: begin
                res.word = rand_word;
                if (pv == PV_ZERO) begin
                    res.word[0] = 1'b0;
                end else if (pv == PV_ONE) begin
                    res.word[0] = 1'b1;
                end
                res.word  = res.word & LANE_MASK;
                res.wr_en = 1'b1;
            end
            REQ_GATE: begin
                res.word  = gate_word & LANE_MASK;
                res.wr_en = 1'b1;
            end
            REQ_COPY, REQ_XFER: begin
                res.word  = w0;
                res.wr_en = 1'b1;
            end
            REQ_CHECK: begin
                res.word     = term_mask;
                res.is_check = last;
                res.mask     = last ? LANE_MASK : term_mask;
            end
            default: begin
                res.word = '0;
            end
        endcase
    end

endmodule

### design/bit_parallel_gate_simulator.sv
// top level of the bit-parallel gate simulator: sequencer, value memory and check mask
//
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    node record (type, node, frame, gate, fanins, word)
//  m_       out  m_valid/m_ready    value_word, is_check_result
//
// a record without a memory read goes from idle straight to the final state; one with n reads
// (n = 1 for copy, transfer and check, 1 to 4 for a gate) reads its fanins in turn, then waits
// for the last word; the single read port of the value memory reads one fanin word per cycle
// reset clears the sequencer and the output valid flag and sets the check mask to all ones
// while the previous result waits on m_ready, the current record holds in its final
// state until the output register frees, and the input stays closed
module bit_parallel_gate_simulator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_req_type,
    input  logic [9:0]                   s_node_index,
    input  logic                         s_frame,
    input  logic [3:0]                   s_gate_kind,
    input  logic [2:0]                   s_fanin_count,
    input  logic [9:0]                   s_fanin_a,
    input  logic [9:0]                   s_fanin_b,
    input  logic [9:0]                   s_fanin_c,
    input  logic [9:0]                   s_fanin_d,
    input  logic [63:0]                  s_random_word,
    input  logic [1:0]                   s_pattern_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [63:0]                  m_value_word,
    output logic                         m_is_check_result
);
    import bpgs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        req_reg, req_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic              wr_frame_reg, wr_frame_next;
    logic              rd_frame_reg, rd_frame_next;
    logic [3:0]        kind_reg, kind_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        pv_reg, pv_next;
    logic              last_reg, last_next;
    logic [WORD_W-1:0] rand_reg, rand_next;
    logic [NODE_W-1:0] fanin_reg [MAX_FANIN];
    logic [NODE_W-1:0] fanin_next [MAX_FANIN];
    logic [FAN_W-1:0]  rd_last_reg, rd_last_next;
    logic [FAN_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              cap_valid_reg, cap_valid_next;
    logic [FAN_W-1:0]  cap_idx_reg, cap_idx_next;
    logic [WORD_W-1:0] w0_reg, w0_next;
    logic [WORD_W-1:0] and_reg, and_next;
    logic [WORD_W-1:0] or_reg, or_next;
    logic [WORD_W-1:0] xor_reg, xor_next;
    logic [WORD_W-1:0] mask_reg, mask_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_word_reg, m_word_next;
    logic              m_check_reg, m_check_next;

    logic [NODE_W-1:0] in_fanin [4];
    logic [CNT_W-1:0]  cnt_sat;
    logic              in_xfer;
    logic              needs_read;
    logic              out_free;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    eval_res_t         res;

    assign in_fanin[0] = (s_req_type == REQ_CHECK) ? s_node_index[NODE_W-1:0]
                                                  : s_fanin_a[NODE_W-1:0];
    assign in_fanin[1] = s_fanin_b[NODE_W-1:0];
    assign in_fanin[2] = s_fanin_c[NODE_W-1:0];
    assign in_fanin[3] = s_fanin_d[NODE_W-1:0];

    assign cnt_sat = (s_fanin_count > 3'(MAX_FANIN)) ? CNT_W'(MAX_FANIN)
                                                    : CNT_W'(s_fanin_count);
    assign in_xfer = (s_req_type == REQ_XFER);
    assign needs_read = (s_req_type == REQ_GATE) || (s_req_type == REQ_COPY) ||
                        (s_req_type == REQ_XFER) || (s_req_type == REQ_CHECK);

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign ram_we    = (state_reg == ST_FIN) && out_free && res.wr_en;
    assign ram_waddr = {wr_frame_reg, node_reg};
    assign ram_raddr = {rd_frame_reg, fanin_reg[rd_cnt_reg]};

    bpgs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (res.word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpgs_eval u_eval (
        .req       (req_reg),
        .kind      (kind_reg),
        .pv        (pv_reg),
        .last      (last_reg),
        .rand_word (rand_reg),
        .w0        (w0_reg),
        .acc_and   (and_reg),
        .acc_or    (or_reg),
        .acc_xor   (xor_reg),
        .mask      (mask_reg),
        .res       (res)
    );

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        node_next      = node_reg;
        wr_frame_next  = wr_frame_reg;
        rd_frame_next  = rd_frame_reg;
        kind_next      = kind_reg;
        cnt_next       = cnt_reg;
        pv_next        = pv_reg;
        last_next      = last_reg;
        rand_next      = rand_reg;
        fanin_next     = fanin_reg;
        rd_last_next   = rd_last_reg;
        rd_cnt_next    = rd_cnt_reg;
        cap_valid_next = 1'b0;
        cap_idx_next   = cap_idx_reg;
        w0_next        = w0_reg;
        and_next       = and_reg;
        or_next        = or_reg;
        xor_next       = xor_reg;
        mask_next      = mask_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_word_next    = m_word_reg;
        m_check_next   = m_check_reg;

        // fold a returning fanin word
        if (cap_valid_reg) begin
            if (cap_idx_reg == '0) begin
                w0_next = ram_rdata;
            end
            if (CNT_W'(cap_idx_reg) < cnt_reg) begin
                and_next = and_reg & ram_rdata;
                or_next  = or_reg | ram_rdata;
                xor_next = xor_reg ^ ram_rdata;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next      = s_req_type;
                    node_next     = s_node_index[NODE_W-1:0];
                    wr_frame_next = in_xfer ? 1'b1 : s_frame;
                    rd_frame_next = in_xfer ? 1'b0 : s_frame;
                    kind_next     = s_gate_kind;
                    cnt_next      = cnt_sat;
                    pv_next       = s_pattern_value;
                    last_next     = s_last;
                    rand_next     = s_random_word;
                    for (int i = 0; i < MAX_FANIN; i++) begin
                        fanin_next[i] = in_fanin[i];
                    end
                    if (s_req_type == REQ_GATE && cnt_sat > CNT_W'(1)) begin
                        rd_last_next = FAN_W'(cnt_sat - CNT_W'(1));
                    end else begin
                        rd_last_next = '0;
                    end
                    rd_cnt_next = '0;
                    w0_next     = '0;
                    and_next    = '1;
                    or_next     = '0;
                    xor_next    = '0;
                    state_next  = needs_read ? ST_READ : ST_FIN;
                end
            end
            ST_READ: begin
                cap_valid_next = 1'b1;
                cap_idx_next   = rd_cnt_reg;
                if (rd_cnt_reg == rd_last_reg) begin
                    state_next = ST_WAIT;
                end else begin
                    rd_cnt_next = rd_cnt_reg + FAN_W'(1);
                end
            end
            ST_WAIT: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res.word;
                    m_check_next = res.is_check;
                    mask_next    = res.mask;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_valid_reg <= 1'b0;
            mask_reg      <= LANE_MASK;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_valid_reg <= cap_valid_next;
            mask_reg      <= mask_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        node_reg     <= node_next;
        wr_frame_reg <= wr_frame_next;
        rd_frame_reg <= rd_frame_next;
        kind_reg     <= kind_next;
        cnt_reg      <= cnt_next;
        pv_reg       <= pv_next;
        last_reg     <= last_next;
        rand_reg     <= rand_next;
        fanin_reg    <= fanin_next;
        rd_last_reg  <= rd_last_next;
        rd_cnt_reg   <= rd_cnt_next;
        cap_idx_reg  <= cap_idx_next;
        w0_reg       <= w0_next;
        and_reg      <= and_next;
        or_reg       <= or_next;
        xor_reg      <= xor_next;
        m_word_reg   <= m_word_next;
        m_check_reg  <= m_check_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_value_word      = m_word_reg;
    assign m_is_check_result = m_check_reg;

    // one record at a time: an accepted transfer closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a record is in progress");

    // the value memory is written only when the result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == ST_FIN && out_free && !(req_reg == REQ_CHECK))
        else $error("value memory written outside the final cycle");

    // returning read data always follows a read cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cap_valid_reg |-> $past(state_reg == ST_READ))
        else $error("read data captured without a read");

    // a completed check leaves the mask at all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && out_free && res.is_check |=> mask_reg == LANE_MASK)
        else $error("check mask not restored after last term");

endmodule

### verif/tb_top.sv
// self-checking testbench of the bit-parallel gate simulator: directed records, random netlists, stalls
`timescale 1ns / 1ps

module tb_top;
    import bpgs_pkg::*;

    localparam logic [2:0] REQ_BAD_LO   = 3'd5;
    localparam logic [2:0] REQ_BAD_HI   = 3'd7;
    localparam logic [3:0] GK_UNUSED_LO = 4'd10;
    localparam logic [3:0] GK_UNUSED_HI = 4'd15;
    localparam logic [1:0] PV_X         = 2'd2;
    localparam logic [1:0] PV_X_ALT     = 2'd3;

    localparam logic [NODE_W-1:0] NODE_TOP = NODE_W'(NODES - 1);

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 530;
    localparam int HOLD_ITEMS     = 40;
    localparam int BURST_ITEMS    = 60;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [2:0]        req;
        logic [NODE_W-1:0] node;
        logic              frame;
        logic [3:0]        kind;
        logic [2:0]        cnt;
        logic [NODE_W-1:0] fa;
        logic [NODE_W-1:0] fb;
        logic [NODE_W-1:0] fc;
        logic [NODE_W-1:0] fd;
        logic [WORD_W-1:0] rnd;
        logic [1:0]        pv;
        logic              last;
    } node_rec_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              chk;
    } result_t;

    logic              aclk              = 1'b0;
    logic              aresetn           = 1'b0;
    logic              s_valid           = 1'b0;
    logic              s_ready;
    logic [2:0]        s_req_type        = '0;
    logic [9:0]        s_node_index      = '0;
    logic              s_frame           = 1'b0;
    logic [3:0]        s_gate_kind       = '0;
    logic [2:0]        s_fanin_count     = '0;
    logic [9:0]        s_fanin_a         = '0;
    logic [9:0]        s_fanin_b         = '0;
    logic [9:0]        s_fanin_c         = '0;
    logic [9:0]        s_fanin_d         = '0;
    logic [63:0]       s_random_word     = '0;
    logic [1:0]        s_pattern_value   = '0;
    logic              s_last            = 1'b0;
    logic              m_valid;
    logic              m_ready           = 1'b0;
    logic [63:0]       m_value_word;
    logic              m_is_check_result;

    // predictor state
    logic [WORD_W-1:0] node_words [0:DEPTH-1];
    bit                node_set   [0:DEPTH-1];
    logic [NODE_W-1:0] live_f0 [$];
    logic [NODE_W-1:0] live_f1 [$];
    logic [WORD_W-1:0] run_mask;
    result_t           expected_results [$];

    int      items_sent  = 0;
    int      fail_count  = 0;
    int      idle_cycles = 0;
    int      hold_left   = 0;
    int      stall_left  = 0;
    int      rx_gap;
    logic    hold_req    = 1'b0;
    bit      quiet       = 1'b0;
    result_t want;

    bit_parallel_gate_simulator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_node_index      (s_node_index),
        .s_frame           (s_frame),
        .s_gate_kind       (s_gate_kind),
        .s_fanin_count     (s_fanin_count),
        .s_fanin_a         (s_fanin_a),
        .s_fanin_b         (s_fanin_b),
        .s_fanin_c         (s_fanin_c),
        .s_fanin_d         (s_fanin_d),
        .s_random_word     (s_random_word),
        .s_pattern_value   (s_pattern_value),
        .s_last            (s_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_value_word      (m_value_word),
        .m_is_check_result (m_is_check_result)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap(int idle_pct);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r >= idle_pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [NODE_W-1:0] rand_node();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return NODE_TOP;
        if (r < 70) return NODE_W'($urandom_range(0, 63));
        return NODE_W'($urandom_range(0, NODES - 1));
    endfunction

    function automatic logic [NODE_W-1:0] pick_live(logic f);
        if (f) return live_f1[$urandom_range(0, live_f1.size() - 1)];
        return live_f0[$urandom_range(0, live_f0.size() - 1)];
    endfunction

    function automatic logic [3:0] rand_kind();
        if ($urandom_range(0, 99) < 95) return 4'($urandom_range(GK_C0, GK_XNOR));
        return 4'($urandom_range(GK_UNUSED_LO, GK_UNUSED_HI));
    endfunction

    function automatic logic [2:0] rand_count();
        if ($urandom_range(0, 99) < 80) return 3'($urandom_range(1, MAX_FANIN));
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic node_rec_t noise_rec();
        node_rec_t r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return r;
    endfunction

    function automatic node_rec_t input_rec(logic [NODE_W-1:0] n, logic f,
                                            logic [WORD_W-1:0] w, logic [1:0] pv);
        node_rec_t r;
        r       = noise_rec();
        r.req   = REQ_INPUT;
        r.node  = n;
        r.frame = f;
        r.rnd   = w;
        r.pv    = pv;
        return r;
    endfunction

    function automatic node_rec_t gate_rec(logic [NODE_W-1:0] n, logic f, logic [3:0] kind,
                                           logic [2:0] cnt, logic [NODE_W-1:0] a,
                                           logic [NODE_W-1:0] b, logic [NODE_W-1:0] c,
                                           logic [NODE_W-1:0] d);
        node_rec_t r;
        r       = noise_rec();
        r.req   = REQ_GATE;
        r.node  = n;
        r.frame = f;
        r.kind  = kind;
        r.cnt   = cnt;
        r.fa    = a;
        r.fb    = b;
        r.fc    = c;
        r.fd    = d;
        return r;
    endfunction

    function automatic node_rec_t check_rec(logic [NODE_W-1:0] n, logic f, logic [1:0] pv,
                                            logic last);
        node_rec_t r;
        r       = noise_rec();
        r.req   = REQ_CHECK;
        r.node  = n;
        r.frame = f;
        r.pv    = pv;
        r.last  = last;
        return r;
    endfunction

    function automatic node_rec_t random_record();
        node_rec_t r;
        int        pick;
        r    = noise_rec();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            r.req  = REQ_INPUT;
            r.node = rand_node();
        end else if (pick < 55) begin
            r = gate_rec(rand_node(), r.frame, rand_kind(), rand_count(), pick_live(r.frame),
                         pick_live(r.frame), pick_live(r.frame), pick_live(r.frame));
        end else if (pick < 65) begin
            r.req  = REQ_COPY;
            r.node = rand_node();
            r.fa   = pick_live(r.frame);
        end else if (pick < 75) begin
            r.req  = REQ_XFER;
            r.node = rand_node();
            r.fa   = pick_live(1'b0);
        end else if (pick < 95) begin
            r.req  = REQ_CHECK;
            r.node = pick_live(r.frame);
        end else begin
            r.req  = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] gate_word(logic [3:0] kind, logic [2:0] cnt,
                                                    logic [WORD_W-1:0] w0,
                                                    logic [WORD_W-1:0] w1,
                                                    logic [WORD_W-1:0] w2,
                                                    logic [WORD_W-1:0] w3);
        logic [WORD_W-1:0] w [4];
        logic [WORD_W-1:0] all_and;
        logic [WORD_W-1:0] any_or;
        logic [WORD_W-1:0] par;
        logic [WORD_W-1:0] y;
        int                n;
        w[0]    = w0;
        w[1]    = w1;
        w[2]    = w2;
        w[3]    = w3;
        n       = (cnt > MAX_FANIN) ? MAX_FANIN : int'(cnt);
        all_and = '1;
        any_or  = '0;
        par     = '0;
        for (int i = 0; i < n; i++) begin
            all_and &= w[i];
            any_or  |= w[i];
            par     ^= w[i];
        end
        case (kind)
            GK_C1:   y = '1;
            GK_BUF:  y = w0;
            GK_NOT:  y = ~w0;
            GK_AND:  y = all_and;
            GK_NAND: y = ~all_and;
            GK_OR:   y = any_or;
            GK_NOR:  y = ~any_or;
            GK_XOR:  y = par;
            GK_XNOR: y = ~par;
            default: y = '0;
        endcase
        return y & LANE_MASK;
    endfunction

    function automatic void store_word(logic f, logic [NODE_W-1:0] n, logic [WORD_W-1:0] w);
        node_words[{f, n}] = w;
        if (!node_set[{f, n}]) begin
            node_set[{f, n}] = 1'b1;
            if (f) live_f1.insert(live_f1.size(), n);
            else live_f0.insert(live_f0.size(), n);
        end
    endfunction

    function automatic void predict(node_rec_t r);
        result_t           e;
        logic [WORD_W-1:0] v;
        e.word = '0;
        e.chk  = 1'b0;
        case (r.req)
            REQ_INPUT: begin
                e.word = r.rnd;
                if (r.pv == PV_ZERO) e.word[0] = 1'b0;
                else if (r.pv == PV_ONE) e.word[0] = 1'b1;
                e.word &= LANE_MASK;
                store_word(r.frame, r.node, e.word);
            end
            REQ_GATE: begin
                e.word = gate_word(r.kind, r.cnt, node_words[{r.frame, r.fa}],
                                   node_words[{r.frame, r.fb}], node_words[{r.frame, r.fc}],
                                   node_words[{r.frame, r.fd}]);
                store_word(r.frame, r.node, e.word);
            end
            REQ_COPY: begin
                e.word = node_words[{r.frame, r.fa}];
                store_word(r.frame, r.node, e.word);
            end
            REQ_XFER: begin
                e.word = node_words[{1'b0, r.fa}];
                store_word(1'b1, r.node, e.word);
            end
            REQ_CHECK: begin
                v = node_words[{r.frame, r.node}];
                if (r.pv == PV_ONE) run_mask &= v;
                else if (r.pv == PV_ZERO) run_mask &= ~v;
                run_mask &= LANE_MASK;
                e.word = run_mask;
                if (r.last) begin
                    e.chk    = 1'b1;
                    run_mask = LANE_MASK;
                end
            end
            default: ;
        endcase
        expected_results.insert(expected_results.size(), e);
    endfunction

    // valid is only lowered when a gap follows, so back-to-back records keep it high
    task automatic send_record(input node_rec_t r);
        int gap;
        gap = pick_gap(50);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= r.req;
        s_node_index    <= r.node;
        s_frame         <= r.frame;
        s_gate_kind     <= r.kind;
        s_fanin_count   <= r.cnt;
        s_fanin_a       <= r.fa;
        s_fanin_b       <= r.fb;
        s_fanin_c       <= r.fc;
        s_fanin_d       <= r.fd;
        s_random_word   <= r.rnd;
        s_pattern_value <= r.pv;
        s_last          <= r.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict(r);
        items_sent++;
    endtask

    // inputs, gates over them, a copy, a transfer, then a check list that ends in last
    task automatic run_netlist(input int n_in, input int n_gate);
        logic [NODE_W-1:0] made [$];
        logic [NODE_W-1:0] fan [4];
        logic [NODE_W-1:0] n;
        logic [1:0]        pv;
        node_rec_t         r;
        logic              f;
        int                n_chk;
        f = 1'($urandom_range(0, 1));
        for (int i = 0; i < n_in; i++) begin
            n = rand_node();
            send_record(input_rec(n, f, {$urandom, $urandom}, 2'($urandom_range(0, 3))));
            made.insert(made.size(), n);
        end
        for (int i = 0; i < n_gate; i++) begin
            n = rand_node();
            for (int j = 0; j < 4; j++) fan[j] = made[$urandom_range(0, made.size() - 1)];
            send_record(gate_rec(n, f, rand_kind(), rand_count(), fan[0], fan[1], fan[2],
                                 fan[3]));
            made.insert(made.size(), n);
        end
        r       = noise_rec();
        r.req   = REQ_COPY;
        r.node  = rand_node();
        r.frame = f;
        r.fa    = made[$urandom_range(0, made.size() - 1)];
        send_record(r);
        made.insert(made.size(), r.node);
        r      = noise_rec();
        r.req  = REQ_XFER;
        r.node = rand_node();
        r.fa   = pick_live(1'b0);
        send_record(r);
        n_chk = $urandom_range(1, 4);
        for (int i = 0; i < n_chk; i++) begin
            n = made[$urandom_range(0, made.size() - 1)];
            if ($urandom_range(0, 99) < 80) pv = {1'b0, node_words[{f, n}][0]};
            else pv = 2'($urandom_range(0, 3));
            send_record(check_rec(n, f, pv, i == n_chk - 1));
        end
    endtask

    task automatic test_input_nodes();
        send_record(input_rec('0, 1'b0, '1, PV_ZERO));
        send_record(input_rec(NODE_TOP, 1'b0, '0, PV_ONE));
        send_record(input_rec(10'd5, 1'b0, {$urandom, $urandom}, PV_X));
        send_record(input_rec(NODE_TOP, 1'b1, {$urandom, $urandom}, PV_X_ALT));
        send_record(input_rec('0, 1'b1, '1, PV_ONE));
    endtask

    task automatic test_gate_kinds();
        send_record(gate_rec(10'd600, 1'b0, GK_C0,   3'd4, '0, NODE_TOP, 10'd5, '0));
        send_record(gate_rec(10'd601, 1'b0, GK_C1,   3'd5, '0, NODE_TOP, 10'd5, '0));
        send_record(gate_rec(10'd602, 1'b0, GK_BUF,  3'd0, 10'd5, '0, NODE_TOP, '0));
        send_record(gate_rec(10'd603, 1'b0, GK_NOT,  3'd7, NODE_TOP, '0, 10'd5, '0));
        send_record(gate_rec(10'd604, 1'b0, GK_AND,  3'd0, '0, NODE_TOP, 10'd5, '0));
        send_record(gate_rec(10'd605, 1'b0, GK_NAND, 3'd1, 10'd5, NODE_TOP, '0, '0));
        send_record(gate_rec(10'd606, 1'b0, GK_OR,   3'd2, '0, NODE_TOP, 10'd5, '0));
        send_record(gate_rec(10'd607, 1'b0, GK_NOR,  3'd3, 10'd5, '0, NODE_TOP, '0));
        send_record(gate_rec(10'd608, 1'b0, GK_XOR,  3'd4, '0, NODE_TOP, 10'd5, 10'd604));
        send_record(gate_rec(10'd609, 1'b0, GK_XNOR, 3'd6, 10'd605, 10'd608, 10'd5, '0));
        send_record(gate_rec(10'd610, 1'b0, GK_UNUSED_LO, 3'd2, '0, NODE_TOP, 10'd5, '0));
        send_record(gate_rec(10'd611, 1'b0, GK_UNUSED_HI, 3'd4, '0, NODE_TOP, 10'd5, '0));
    endtask

    task automatic test_copy_and_transfer();
        node_rec_t r;
        r       = noise_rec();
        r.req   = REQ_COPY;
        r.node  = 10'd700;
        r.frame = 1'b1;
        r.fa    = '0;
        send_record(r);
        r       = noise_rec();
        r.req   = REQ_XFER;
        r.node  = 10'd9;
        r.frame = 1'b1;
        r.fa    = NODE_TOP;
        send_record(r);
    endtask

    task automatic test_check_terms();
        send_record(check_rec('0, 1'b0, PV_ONE, 1'b0));
        send_record(check_rec(NODE_TOP, 1'b0, PV_ZERO, 1'b0));
        send_record(check_rec(NODE_TOP, 1'b1, PV_X, 1'b0));
        send_record(check_rec(10'd5, 1'b0, PV_X_ALT, 1'b1));
        send_record(check_rec(10'd9, 1'b1, PV_ONE, 1'b1));
    endtask

    task automatic test_unknown_requests();
        node_rec_t r;
        r     = noise_rec();
        r.req = REQ_BAD_LO;
        send_record(r);
        r     = noise_rec();
        r.req = REQ_BAD_HI;
        send_record(r);
    endtask

    task automatic test_random_netlists();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 75) begin
                run_netlist($urandom_range(1, 4), $urandom_range(1, 8));
            end else begin
                repeat ($urandom_range(1, 4)) send_record(random_record());
            end
        end
    endtask

    task automatic test_receiver_hold();
        int stop_at;
        hold_req <= 1'b1;
        stop_at = items_sent + HOLD_ITEMS;
        while (items_sent < stop_at) run_netlist(2, 3);
    endtask

    task automatic test_no_idle();
        int stop_at;
        quiet   = 1'b1;
        stop_at = items_sent + BURST_ITEMS;
        while (items_sent < stop_at) run_netlist($urandom_range(1, 3), $urandom_range(1, 6));
        quiet = 1'b0;
    endtask

    // result receiver with random stalls and one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            rx_gap = pick_gap(30);
            m_ready    <= (rx_gap == 0);
            stall_left <= (rx_gap > 0) ? rx_gap - 1 : 0;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: value_word %h is_check_result %0d",
                             m_value_word, m_is_check_result);
            end else begin
                want = expected_results.pop_front();
                if (m_value_word !== want.word || m_is_check_result !== want.chk) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: value_word exp %h got %h, ",
                                  "is_check_result exp %0d got %0d"},
                                 want.word, m_value_word, want.chk, m_is_check_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        run_mask = LANE_MASK;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_input_nodes();
        test_gate_kinds();
        test_copy_and_transfer();
        test_check_terms();
        test_unknown_requests();
        test_random_netlists();
        test_receiver_hold();
        test_no_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### files.f
design/bpgs_pkg.sv
design/bpgs_ram.sv
design/bpgs_eval.sv
design/bit_parallel_gate_simulator.sv
verif/tb_top.sv
